[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// pre implies post in the same cycle
`define ASSERT_IMPLY(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// pre implies post in the next cycle
`define ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[hw/rtl/ljpf_pkg.sv]
// Package: constants, types and state encodings of the Lennard-Jones force block.
package ljpf_pkg;

   localparam int DIM             = 3;
   localparam int IMAGES_PER_AXIS = 3;
   localparam int NUM_AXES        = 3;
   localparam int AX_W            = 2;
   localparam int CNT_W           = $clog2(IMAGES_PER_AXIS + 1);
   localparam int IDX_W           = (IMAGES_PER_AXIS > 1) ? $clog2(IMAGES_PER_AXIS) : 1;

   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   // range divider: 34-bit magnitude, one quotient bit per cycle
   localparam int DIV_STEPS       = 34;
   localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
   // reciprocal divider: 2^64 / s, 65 quotient bits
   localparam int RECIP_STEPS     = 65;
   localparam int RECIP_CNT_W     = $clog2(RECIP_STEPS);
   // r^-14 and r^-8 built from seven and four multiplies by 1/r^2
   localparam int POW_T1_STEPS    = 7;
   localparam int POW_STEPS       = 11;
   localparam int POW_CNT_W       = $clog2(POW_STEPS);

   localparam logic [30:0] BOX_RESET    = 31'd65536;
   localparam logic [30:0] CUTOFF_RESET = 31'd32768;
   localparam logic [47:0] MAX48        = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] FMAX         = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] FMIN         = 48'h8000_0000_0000;

   typedef enum logic [2:0] {
      CSR_BOX_X,
      CSR_BOX_Y,
      CSR_BOX_Z,
      CSR_CUTOFF,
      CSR_C12,
      CSR_C6,
      CSR_C_SHIFT
   } csr_index_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][30:0] box;
      logic [30:0]               cutoff;
      logic [47:0]               c12;
      logic [47:0]               c6;
      logic [47:0]               c_shift;
   } cfg_type;

   // per-axis image range: first k, image count, first offset, box step
   typedef struct packed {
      logic [34:0]      lo;
      logic [CNT_W-1:0] cnt;
      logic [31:0]      z0;
      logic [30:0]      d;
   } axis_job_type;

   typedef struct packed {
      axis_job_type [NUM_AXES-1:0] ax;
      logic                        excl;
      logic                        sat;
   } job_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_LOAD,
      F_DIV,
      F_FIX,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_R2CUT,
      B_SQ,
      B_CHECK,
      B_RECIP,
      B_POW,
      B_POWFIX,
      B_COEF,
      B_FMUL,
      B_FADD,
      B_NEXT,
      B_DONE
   } back_state_type;

endpackage

[hw/rtl/ljpf_channels.sv]
// Channel interfaces: request beat (point pair) and response beat (force).
interface ljpf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_pos_0;
   logic signed [31:0] x_pos_1;
   logic signed [31:0] x_pos_2;
   logic signed [31:0] y_pos_0;
   logic signed [31:0] y_pos_1;
   logic signed [31:0] y_pos_2;
   logic [15:0]        x_molecule;
   logic [15:0]        y_molecule;

   modport source (output valid, x_pos_0, x_pos_1, x_pos_2, y_pos_0, y_pos_1, y_pos_2,
                   x_molecule, y_molecule, input ready);
   modport sink (input valid, x_pos_0, x_pos_1, x_pos_2, y_pos_0, y_pos_1, y_pos_2,
                 x_molecule, y_molecule, output ready);
endinterface

interface ljpf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] force_0;
   logic signed [47:0] force_1;
   logic signed [47:0] force_2;
   logic               saturated;

   modport source (output valid, force_0, force_1, force_2, saturated, input ready);
   modport sink (input valid, force_0, force_1, force_2, saturated, output ready);
endinterface

[hw/rtl/lennard_jones_periodic_force_top.sv]
// Top level of the Lennard-Jones periodic pair force block.
// Each request beat carries two Q16.16 points and their molecule numbers; one response
// beat returns the Q24.24 force summed over all periodic images of the second point that
// lie inside the cutoff, plus a flag set when any count or value was clipped. The front
// end runs two 34-step range divisions per axis for each beat. For each image inside the
// cutoff the force engine then runs the 2^64/r^2 reciprocal divider, eleven 48x64
// multiplies on the one 32x32 multiplier and the three force terms, besides the squares
// and bookkeeping; for an image it skips it only sums the squares and moves on. A
// two-entry queue lets the front end range the next pair meanwhile. Register writes go
// through the csr port; the user must make them only while the block is idle, which
// the block itself does not enforce.
`include "assert_macros.svh"

module lennard_jones_periodic_force_top (
   input  logic        clock,
   input  logic        reset,
   ljpf_req_if.sink    req_chan,
   ljpf_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   // configuration registers
   logic [30:0] box_x_ff;
   logic [30:0] box_y_ff;
   logic [30:0] box_z_ff;
   logic [30:0] cutoff_ff;
   logic [47:0] c12_ff;
   logic [47:0] c6_ff;
   logic [47:0] c_shift_ff;

   ljpf_pkg::cfg_type cfg;
   logic              fe_valid;
   logic              fe_ready;
   ljpf_pkg::job_type fe_job;
   logic              be_valid;
   logic              be_ready;
   ljpf_pkg::job_type be_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff   <= ljpf_pkg::BOX_RESET;
         box_y_ff   <= ljpf_pkg::BOX_RESET;
         box_z_ff   <= ljpf_pkg::BOX_RESET;
         cutoff_ff  <= ljpf_pkg::CUTOFF_RESET;
         c12_ff     <= '0;
         c6_ff      <= '0;
         c_shift_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            ljpf_pkg::CSR_BOX_X:   box_x_ff   <= csr_wdata[30:0];
            ljpf_pkg::CSR_BOX_Y:   box_y_ff   <= csr_wdata[30:0];
            ljpf_pkg::CSR_BOX_Z:   box_z_ff   <= csr_wdata[30:0];
            ljpf_pkg::CSR_CUTOFF:  cutoff_ff  <= csr_wdata[30:0];
            ljpf_pkg::CSR_C12:     c12_ff     <= csr_wdata;
            ljpf_pkg::CSR_C6:      c6_ff      <= csr_wdata;
            ljpf_pkg::CSR_C_SHIFT: c_shift_ff <= csr_wdata;
            default: begin
               // unmapped index: write is dropped
               c6_ff <= c6_ff;
            end
         endcase
      end
   end

   always_comb begin
      cfg.box[0]  = box_x_ff;
      cfg.box[1]  = box_y_ff;
      cfg.box[2]  = box_z_ff;
      cfg.cutoff  = cutoff_ff;
      cfg.c12     = c12_ff;
      cfg.c6      = c6_ff;
      cfg.c_shift = c_shift_ff;
   end

   // front end: image range per axis
   ljpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg),
      .job_valid (fe_valid),
      .job       (fe_job),
      .job_ready (fe_ready)
   );

   // decoupling queue
   ljpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_ready (fe_ready),
      .push_data  (fe_job),
      .pop_valid  (be_valid),
      .pop_ready  (be_ready),
      .pop_data   (be_job)
   );

   // force engine with its own output register
   ljpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_valid (be_valid),
      .job_ready (be_ready),
      .job       (be_job),
      .rsp_chan  (rsp_chan)
   );

endmodule

[hw/rtl/ljpf_front.sv]
// Front end: accepts a point pair and works out the image range on each axis.
`include "assert_macros.svh"

module ljpf_front (
   input  logic              clock,
   input  logic              reset,
   ljpf_req_if.sink          req_chan,
   input  ljpf_pkg::cfg_type cfg,
   output logic              job_valid,
   output ljpf_pkg::job_type job,
   input  logic              job_ready
);

   ljpf_pkg::front_state_type state_ff, state_in;

   logic [ljpf_pkg::NUM_AXES-1:0][32:0] diff_ff;
   logic [ljpf_pkg::AX_W-1:0]           ax_ff;
   logic                                phase_ff;
   logic [ljpf_pkg::DIV_CNT_W-1:0]      step_ff;
   logic [33:0]                         quo_ff;
   logic [30:0]                         rem_ff;
   logic                                neg_ff;
   ljpf_pkg::job_type                   job_ff;

   logic [30:0] d_cur;
   logic [34:0] num_s;
   logic [33:0] num_mag;
   logic [31:0] trial;
   logic        trial_ge;
   logic [30:0] rem_nx;
   logic [34:0] q_s;
   logic [30:0] r_adj;
   logic [34:0] lo_val;
   logic [30:0] gap;
   logic [31:0] z0_val;
   logic [35:0] span;
   logic [ljpf_pkg::CNT_W-1:0] cnt_val;
   logic        cnt_clip;
   logic        last_axis;
   logic        div_last;

   // divisor: a zero box counts as one LSB
   assign d_cur = (cfg.box[ax_ff] == 31'd0) ? 31'd1 : cfg.box[ax_ff];

   // phase 0: diff - rad (ceil gives lowest k), phase 1: diff + rad (floor gives highest k)
   always_comb begin
      if (phase_ff) begin
         num_s = {{2{diff_ff[ax_ff][32]}}, diff_ff[ax_ff]} + {4'd0, cfg.cutoff};
      end else begin
         num_s = {{2{diff_ff[ax_ff][32]}}, diff_ff[ax_ff]} - {4'd0, cfg.cutoff};
      end
      num_mag = num_s[34] ? 34'(-num_s) : num_s[33:0];
   end

   // restoring divider step
   always_comb begin
      trial    = {rem_ff, quo_ff[33]};
      trial_ge = trial >= {1'b0, d_cur};
      rem_nx   = trial_ge ? 31'(trial - {1'b0, d_cur}) : trial[30:0];
   end

   // floor quotient and remainder from the magnitude result
   always_comb begin
      if (neg_ff) begin
         q_s = (rem_ff == 31'd0) ? 35'(-{1'b0, quo_ff}) : 35'(-{1'b0, quo_ff} - 35'd1);
      end else begin
         q_s = {1'b0, quo_ff};
      end
      r_adj  = (neg_ff && rem_ff != 31'd0) ? 31'(d_cur - rem_ff) : rem_ff;
      lo_val = q_s + {34'd0, (r_adj != 31'd0)};
      gap    = (r_adj == 31'd0) ? 31'd0 : 31'(d_cur - r_adj);
      z0_val = {1'b0, gap} - {1'b0, cfg.cutoff};
      span   = {q_s[34], q_s} - {job_ff.ax[ax_ff].lo[34], job_ff.ax[ax_ff].lo};
      cnt_clip = 1'b0;
      if (span[35]) begin
         cnt_val = '0;
      end else if (span >= 36'(ljpf_pkg::IMAGES_PER_AXIS)) begin
         cnt_val  = ljpf_pkg::CNT_W'(ljpf_pkg::IMAGES_PER_AXIS);
         cnt_clip = 1'b1;
      end else begin
         cnt_val = ljpf_pkg::CNT_W'(span + 36'd1);
      end
   end

   assign last_axis = ax_ff == ljpf_pkg::AX_W'(ljpf_pkg::DIM - 1);
   assign div_last  = step_ff == ljpf_pkg::DIV_CNT_W'(ljpf_pkg::DIV_STEPS - 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ljpf_pkg::F_IDLE: begin
            if (req_chan.valid) state_in = ljpf_pkg::F_LOAD;
         end
         ljpf_pkg::F_LOAD: state_in = ljpf_pkg::F_DIV;
         ljpf_pkg::F_DIV: begin
            if (div_last) state_in = ljpf_pkg::F_FIX;
         end
         ljpf_pkg::F_FIX: begin
            if (phase_ff && last_axis) state_in = ljpf_pkg::F_PUSH;
            else state_in = ljpf_pkg::F_LOAD;
         end
         ljpf_pkg::F_PUSH: begin
            if (job_ready) state_in = ljpf_pkg::F_IDLE;
         end
         default: state_in = ljpf_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      job_valid      = 1'b0;
      case (state_ff)
         ljpf_pkg::F_IDLE: req_chan.ready = 1'b1;
         ljpf_pkg::F_PUSH: job_valid      = 1'b1;
         default: begin
            req_chan.ready = 1'b0;
            job_valid      = 1'b0;
         end
      endcase
   end

   assign job = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ljpf_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ljpf_pkg::F_IDLE: begin
            if (req_chan.valid) begin
               diff_ff[0] <= {req_chan.x_pos_0[31], req_chan.x_pos_0}
                             - {req_chan.y_pos_0[31], req_chan.y_pos_0};
               diff_ff[1] <= {req_chan.x_pos_1[31], req_chan.x_pos_1}
                             - {req_chan.y_pos_1[31], req_chan.y_pos_1};
               diff_ff[2] <= {req_chan.x_pos_2[31], req_chan.x_pos_2}
                             - {req_chan.y_pos_2[31], req_chan.y_pos_2};
               job_ff.excl <= (req_chan.x_molecule == req_chan.y_molecule)
                              && (req_chan.x_molecule != 16'd0);
               job_ff.sat  <= 1'b0;
               // axes beyond DIM: a single image at zero offset
               for (int a = 0; a < ljpf_pkg::NUM_AXES; a++) begin
                  job_ff.ax[a].lo  <= '0;
                  job_ff.ax[a].cnt <= ljpf_pkg::CNT_W'(1);
                  job_ff.ax[a].z0  <= '0;
                  job_ff.ax[a].d   <= 31'd1;
               end
               ax_ff    <= '0;
               phase_ff <= 1'b0;
            end
         end
         ljpf_pkg::F_LOAD: begin
            quo_ff  <= num_mag;
            neg_ff  <= num_s[34];
            rem_ff  <= '0;
            step_ff <= '0;
         end
         ljpf_pkg::F_DIV: begin
            quo_ff  <= {quo_ff[32:0], trial_ge};
            rem_ff  <= rem_nx;
            step_ff <= step_ff + ljpf_pkg::DIV_CNT_W'(1);
         end
         ljpf_pkg::F_FIX: begin
            if (!phase_ff) begin
               job_ff.ax[ax_ff].lo <= lo_val;
               job_ff.ax[ax_ff].z0 <= z0_val;
               job_ff.ax[ax_ff].d  <= d_cur;
               phase_ff            <= 1'b1;
            end else begin
               job_ff.ax[ax_ff].cnt <= cnt_val;
               if (cnt_clip) job_ff.sat <= 1'b1;
               phase_ff <= 1'b0;
               if (!last_axis) ax_ff <= ax_ff + ljpf_pkg::AX_W'(1);
            end
         end
         default: begin
            ax_ff <= ax_ff;
         end
      endcase
   end

   `ASSERT_IMPLY(a_front_div_range, clock, reset, state_ff == ljpf_pkg::F_DIV, ax_ff <= ljpf_pkg::AX_W'(ljpf_pkg::DIM - 1), "front divides on an axis beyond DIM")

endmodule

[hw/rtl/ljpf_queue.sv]
// Short job queue between the front end and the force engine.
`include "assert_macros.svh"

module ljpf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ljpf_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ljpf_pkg::job_type pop_data
);

   ljpf_pkg::job_type              slot_ff [ljpf_pkg::QUEUE_DEPTH];
   logic [ljpf_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [ljpf_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [ljpf_pkg::QCNT_W-1:0]    count_ff;
   logic                           do_push;
   logic                           do_pop;

   assign push_ready = count_ff != ljpf_pkg::QCNT_W'(ljpf_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == ljpf_pkg::QPTR_W'(ljpf_pkg::QUEUE_DEPTH - 1))
                         ? '0 : wr_ptr_ff + ljpf_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == ljpf_pkg::QPTR_W'(ljpf_pkg::QUEUE_DEPTH - 1))
                         ? '0 : rd_ptr_ff + ljpf_pkg::QPTR_W'(1);
         end
         if (do_push && !do_pop) count_ff <= count_ff + ljpf_pkg::QCNT_W'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - ljpf_pkg::QCNT_W'(1);
      end
   end

   `ASSERT_ALWAYS(a_queue_bound, clock, reset, count_ff <= ljpf_pkg::QCNT_W'(ljpf_pkg::QUEUE_DEPTH), "job queue overfilled")

endmodule

[hw/rtl/ljpf_back.sv]
// Force engine: walks the images of one job and accumulates the pair force.
`include "assert_macros.svh"

module ljpf_back (
   input  logic              clock,
   input  logic              reset,
   input  ljpf_pkg::cfg_type cfg,
   input  logic              job_valid,
   output logic              job_ready,
   input  ljpf_pkg::job_type job,
   ljpf_rsp_if.source        rsp_chan
);

   ljpf_pkg::back_state_type state_ff, state_in;
   ljpf_pkg::job_type        job_ff;

   logic [ljpf_pkg::NUM_AXES-1:0][ljpf_pkg::IDX_W-1:0] idx_ff;
   logic [ljpf_pkg::NUM_AXES-1:0][31:0]                z_ff;
   logic [ljpf_pkg::NUM_AXES-1:0][47:0]                f_ff;
   logic [ljpf_pkg::AX_W-1:0]        ax_ff;
   logic [ljpf_pkg::RECIP_CNT_W-1:0] step_ff;
   logic [ljpf_pkg::POW_CNT_W-1:0]   pw_ff;
   logic [1:0]                       pp_ff;
   logic [63:0]                      r2cut_ff;
   logic [63:0]                      s_ff;
   logic [63:0]                      rem_ff;
   logic [64:0]                      quo_ff;
   logic [63:0]                      u_ff;
   logic [47:0]                      t1_ff;
   logic [47:0]                      t2_ff;
   logic [111:0]                     acc_ff;
   logic [47:0]                      mc_ff;
   logic                             coef_neg_ff;
   logic                             sat_ff;

   logic                                out_valid_ff;
   logic [ljpf_pkg::NUM_AXES-1:0][47:0] out_f_ff;
   logic                                out_sat_ff;

   logic [31:0]  z_cur;
   logic [31:0]  z_mag;
   logic         z_neg;
   logic         origin;
   logic         skip;
   logic         no_images;
   logic         recip_bit;
   logic [64:0]  rtrial;
   logic         rge;
   logic [63:0]  rem_nx;
   logic [64:0]  quo_nx;
   logic [47:0]  t_sel;
   logic [31:0]  mul_a;
   logic [31:0]  mul_b;
   logic [63:0]  mul_p;
   logic [111:0] pp_shifted;
   logic [111:0] acc_nx;
   logic         pow_over;
   logic [47:0]  pow_res;
   logic [49:0]  coef_sum;
   logic [47:0]  coef_val;
   logic         coef_clip;
   logic [62:0]  term;
   logic [63:0]  term_s;
   logic [63:0]  fsum;
   logic [47:0]  f_val;
   logic         f_clip;
   logic [ljpf_pkg::NUM_AXES-1:0][ljpf_pkg::IDX_W-1:0] idx_nx;
   logic [ljpf_pkg::NUM_AXES-1:0][31:0]                z_nx;
   logic         wrap_all;
   logic         last_axis;
   logic         recip_last;
   logic         pow_last;
   logic         out_load;

   assign last_axis  = ax_ff == ljpf_pkg::AX_W'(ljpf_pkg::DIM - 1);
   assign recip_last = step_ff == ljpf_pkg::RECIP_CNT_W'(ljpf_pkg::RECIP_STEPS - 1);
   assign pow_last   = pw_ff == ljpf_pkg::POW_CNT_W'(ljpf_pkg::POW_STEPS - 1);

   assign z_cur = z_ff[ax_ff];
   assign z_neg = z_cur[31];
   assign z_mag = z_neg ? 32'(-z_cur) : z_cur;

   // origin image: k = lo + idx is zero on every axis
   always_comb begin
      origin    = 1'b1;
      no_images = 1'b0;
      for (int a = 0; a < ljpf_pkg::NUM_AXES; a++) begin
         if (36'({job_ff.ax[a].lo[34], job_ff.ax[a].lo} + 36'(idx_ff[a])) != 36'd0) begin
            origin = 1'b0;
         end
         if (job_ff.ax[a].cnt == '0) no_images = 1'b1;
      end
   end

   assign skip = (job_ff.excl && origin) || (s_ff == 64'd0) || (s_ff >= r2cut_ff);

   // reciprocal: restoring division of 2^64 by s
   always_comb begin
      recip_bit = step_ff == '0;
      rtrial    = {rem_ff, recip_bit};
      rge       = rtrial >= {1'b0, s_ff};
      rem_nx    = rge ? 64'(rtrial - {1'b0, s_ff}) : rtrial[63:0];
      quo_nx    = {quo_ff[63:0], rge};
   end

   assign t_sel = (pw_ff < ljpf_pkg::POW_CNT_W'(ljpf_pkg::POW_T1_STEPS)) ? t1_ff : t2_ff;

   // shared 32x32 multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ljpf_pkg::B_R2CUT: begin
            mul_a = {1'b0, cfg.cutoff};
            mul_b = {1'b0, cfg.cutoff};
         end
         ljpf_pkg::B_SQ: begin
            mul_a = z_mag;
            mul_b = z_mag;
         end
         ljpf_pkg::B_POW: begin
            mul_a = pp_ff[1] ? {16'd0, t_sel[47:32]} : t_sel[31:0];
            mul_b = pp_ff[0] ? u_ff[63:32] : u_ff[31:0];
         end
         ljpf_pkg::B_FMUL: begin
            mul_a = z_mag;
            mul_b = pp_ff[0] ? {16'd0, mc_ff[47:32]} : mc_ff[31:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // partial product weights: lo*lo, cross terms at 2^32, hi*hi at 2^64
   always_comb begin
      case (pp_ff)
         2'd0: pp_shifted = {48'd0, mul_p};
         2'd1: pp_shifted = {16'd0, mul_p, 32'd0};
         2'd2: pp_shifted = {16'd0, mul_p, 32'd0};
         2'd3: pp_shifted = {mul_p[47:0], 64'd0};
         default: pp_shifted = '0;
      endcase
      acc_nx = (pp_ff == 2'd0) ? pp_shifted : acc_ff + pp_shifted;
   end

   assign pow_over = acc_ff[111:80] != 32'd0;
   assign pow_res  = pow_over ? ljpf_pkg::MAX48 : acc_ff[79:32];

   always_comb begin
      coef_sum = {2'b00, t1_ff} - {2'b00, t2_ff} + {{2{cfg.c_shift[47]}}, cfg.c_shift};
      coef_clip = (coef_sum[49:47] != 3'b000) && (coef_sum[49:47] != 3'b111);
      if (coef_clip) coef_val = coef_sum[49] ? ljpf_pkg::FMIN : ljpf_pkg::FMAX;
      else coef_val = coef_sum[47:0];
   end

   always_comb begin
      term   = acc_ff[78:16];
      term_s = (z_neg ^ coef_neg_ff) ? 64'(-{1'b0, term}) : {1'b0, term};
      fsum   = {{16{f_ff[ax_ff][47]}}, f_ff[ax_ff]} + term_s;
      f_clip = (fsum[63:47] != 17'h00000) && (fsum[63:47] != 17'h1FFFF);
      if (f_clip) f_val = fsum[63] ? ljpf_pkg::FMIN : ljpf_pkg::FMAX;
      else f_val = fsum[47:0];
   end

   // image odometer, axis 0 fastest
   always_comb begin
      wrap_all = 1'b1;
      idx_nx   = idx_ff;
      z_nx     = z_ff;
      for (int a = 0; a < ljpf_pkg::NUM_AXES; a++) begin
         if (wrap_all) begin
            if (ljpf_pkg::CNT_W'(idx_ff[a]) == job_ff.ax[a].cnt - ljpf_pkg::CNT_W'(1)) begin
               idx_nx[a] = '0;
               z_nx[a]   = job_ff.ax[a].z0;
            end else begin
               idx_nx[a] = idx_ff[a] + ljpf_pkg::IDX_W'(1);
               z_nx[a]   = 32'(z_ff[a] + {1'b0, job_ff.ax[a].d});
               wrap_all  = 1'b0;
            end
         end
      end
   end

   assign out_load = (state_ff == ljpf_pkg::B_DONE) && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ljpf_pkg::B_IDLE: begin
            if (job_valid) state_in = ljpf_pkg::B_R2CUT;
         end
         ljpf_pkg::B_R2CUT: state_in = no_images ? ljpf_pkg::B_DONE : ljpf_pkg::B_SQ;
         ljpf_pkg::B_SQ: begin
            if (last_axis) state_in = ljpf_pkg::B_CHECK;
         end
         ljpf_pkg::B_CHECK: state_in = skip ? ljpf_pkg::B_NEXT : ljpf_pkg::B_RECIP;
         ljpf_pkg::B_RECIP: begin
            if (recip_last) state_in = ljpf_pkg::B_POW;
         end
         ljpf_pkg::B_POW: begin
            if (pp_ff == 2'd3) state_in = ljpf_pkg::B_POWFIX;
         end
         ljpf_pkg::B_POWFIX: state_in = pow_last ? ljpf_pkg::B_COEF : ljpf_pkg::B_POW;
         ljpf_pkg::B_COEF: state_in = ljpf_pkg::B_FMUL;
         ljpf_pkg::B_FMUL: begin
            if (pp_ff == 2'd1) state_in = ljpf_pkg::B_FADD;
         end
         ljpf_pkg::B_FADD: state_in = last_axis ? ljpf_pkg::B_NEXT : ljpf_pkg::B_FMUL;
         ljpf_pkg::B_NEXT: state_in = wrap_all ? ljpf_pkg::B_DONE : ljpf_pkg::B_SQ;
         ljpf_pkg::B_DONE: begin
            if (out_load) state_in = ljpf_pkg::B_IDLE;
         end
         default: state_in = ljpf_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      job_ready = 1'b0;
      case (state_ff)
         ljpf_pkg::B_IDLE: job_ready = 1'b1;
         default: job_ready = 1'b0;
      endcase
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.force_0   = out_f_ff[0];
   assign rsp_chan.force_1   = out_f_ff[1];
   assign rsp_chan.force_2   = out_f_ff[2];
   assign rsp_chan.saturated = out_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ljpf_pkg::B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_chan.ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_f_ff   <= f_ff;
         out_sat_ff <= sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ljpf_pkg::B_IDLE: begin
            if (job_valid) begin
               job_ff <= job;
               sat_ff <= job.sat;
               for (int a = 0; a < ljpf_pkg::NUM_AXES; a++) begin
                  idx_ff[a] <= '0;
                  z_ff[a]   <= job.ax[a].z0;
                  f_ff[a]   <= '0;
               end
            end
         end
         ljpf_pkg::B_R2CUT: begin
            r2cut_ff <= mul_p;
            s_ff     <= '0;
            ax_ff    <= '0;
         end
         ljpf_pkg::B_SQ: begin
            s_ff <= s_ff + mul_p;
            if (!last_axis) ax_ff <= ax_ff + ljpf_pkg::AX_W'(1);
         end
         ljpf_pkg::B_CHECK: begin
            rem_ff  <= '0;
            quo_ff  <= '0;
            step_ff <= '0;
            t1_ff   <= cfg.c12;
            t2_ff   <= cfg.c6;
         end
         ljpf_pkg::B_RECIP: begin
            rem_ff  <= rem_nx;
            quo_ff  <= quo_nx;
            step_ff <= step_ff + ljpf_pkg::RECIP_CNT_W'(1);
            if (recip_last) begin
               u_ff  <= quo_nx[64] ? 64'hFFFF_FFFF_FFFF_FFFF : quo_nx[63:0];
               if (quo_nx[64]) sat_ff <= 1'b1;
               pw_ff <= '0;
               pp_ff <= '0;
            end
         end
         ljpf_pkg::B_POW: begin
            acc_ff <= acc_nx;
            pp_ff  <= pp_ff + 2'd1;
         end
         ljpf_pkg::B_POWFIX: begin
            if (pw_ff < ljpf_pkg::POW_CNT_W'(ljpf_pkg::POW_T1_STEPS)) t1_ff <= pow_res;
            else t2_ff <= pow_res;
            if (pow_over) sat_ff <= 1'b1;
            pw_ff <= pw_ff + ljpf_pkg::POW_CNT_W'(1);
            pp_ff <= '0;
         end
         ljpf_pkg::B_COEF: begin
            coef_neg_ff <= coef_val[47];
            mc_ff       <= coef_val[47] ? 48'(-coef_val) : coef_val;
            if (coef_clip) sat_ff <= 1'b1;
            ax_ff <= '0;
            pp_ff <= '0;
         end
         ljpf_pkg::B_FMUL: begin
            acc_ff <= acc_nx;
            pp_ff  <= pp_ff + 2'd1;
         end
         ljpf_pkg::B_FADD: begin
            f_ff[ax_ff] <= f_val;
            if (f_clip) sat_ff <= 1'b1;
            pp_ff <= '0;
            if (!last_axis) ax_ff <= ax_ff + ljpf_pkg::AX_W'(1);
         end
         ljpf_pkg::B_NEXT: begin
            idx_ff <= idx_nx;
            z_ff   <= z_nx;
            s_ff   <= '0;
            ax_ff  <= '0;
         end
         default: begin
            ax_ff <= ax_ff;
         end
      endcase
   end

   `ASSERT_NEXT(a_back_out_load, clock, reset, out_load, rsp_chan.valid, "loaded result not presented")
   `ASSERT_IMPLY(a_back_pow_range, clock, reset, state_ff == ljpf_pkg::B_POWFIX, pw_ff <= ljpf_pkg::POW_CNT_W'(ljpf_pkg::POW_STEPS - 1), "power step count ran past the last multiply")

endmodule

[dv/lennard_jones_periodic_force_top_tb.sv]
// Testbench: point pairs with random pacing, per-beat force checks against an internal predictor.
`timescale 1ns / 100ps

module lennard_jones_periodic_force_top_tb;

   localparam int  WATCHDOG_LIMIT   = 20000; // covers the slowest beat plus the long hold
   localparam int  HOLD_CYCLES      = 3000;  // long receiver stall, fills the two-entry queue
   localparam int  RANDOM_PER_PHASE = 80;    // six random phases, ~500 beats in all
   localparam int  REPORT_LIMIT     = 10;
   localparam int  DIR_ROWS         = 14;
   localparam int  NEAR_SPAN        = 3 * 65536;     // +-3.0 in Q16.16
   localparam longint F_HI          = 64'sh7FFF_FFFF_FFFF;
   localparam longint F_LO          = -64'sh8000_0000_0000;

   typedef struct {
      logic signed [31:0] xp [3];
      logic signed [31:0] yp [3];
      logic [15:0]        xm;
      logic [15:0]        ym;
   } pair_type;

   typedef struct packed {
      logic [47:0] f0;
      logic [47:0] f1;
      logic [47:0] f2;
      logic        sat;
   } force_type;

   typedef struct {
      pair_type  p;
      bit        typed;   // expected force written into the row
      force_type exp;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [47:0] csr_wdata;

   ljpf_req_if req_if ();
   ljpf_rsp_if rsp_if ();

   lennard_jones_periodic_force_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the register file
   logic [30:0] cfg_box [3];
   logic [30:0] cfg_cutoff;
   logic [47:0] cfg_c12;
   logic [47:0] cfg_c6;
   logic [47:0] cfg_c_shift;

   force_type   force_q [$];   // forces still owed by the block, oldest first
   int          mismatches;
   int          idle_cycles;
   bit          hold_pending;
   dir_row_type dir_rows [DIR_ROWS];

   // 20 ns clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint div_floor(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d != 0) && (n < 0)) q = q - 1;
      return q;
   endfunction

   function automatic longint div_ceil(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d != 0) && (n > 0)) q = q + 1;
      return q;
   endfunction

   // floor(a*b / 2^k), clipped to cap
   function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                  input int k, input logic [63:0] cap,
                                                  inout bit sat);
      logic [127:0] pp;
      pp = ({64'd0, a} * {64'd0, b}) >> k;
      if (pp > {64'd0, cap}) begin
         sat = 1'b1;
         return cap;
      end
      return pp[63:0];
   endfunction

   function automatic force_type predict_force(pair_type p);
      longint      diff [3], dd [3], kmin [3], cnt [3], zz [3], f [3];
      longint      rad, cs, total, rem, k, lo, hi, coef, term;
      logic [63:0] r2cut, s, u, t1, t2, mz, mc, pr;
      logic [64:0] q;
      bit          sat, excl, origin;
      force_type   r;
      rad   = longint'(cfg_cutoff);
      cs    = longint'($signed(cfg_c_shift));
      r2cut = 64'(rad) * 64'(rad);
      sat   = 1'b0;
      total = 1;
      excl  = (p.xm == p.ym) && (p.xm != 16'd0);
      for (int a = 0; a < 3; a++) begin
         f[a]    = 0;
         diff[a] = 0;
         cnt[a]  = 1;
         kmin[a] = 0;
         dd[a]   = 1;
      end
      for (int a = 0; a < ljpf_pkg::DIM; a++) begin
         diff[a] = longint'(p.xp[a]) - longint'(p.yp[a]);
         dd[a]   = (cfg_box[a] != 31'd0) ? longint'(cfg_box[a]) : 1;   // zero box acts as 1 LSB
         lo      = div_ceil(diff[a] - rad, dd[a]);
         hi      = div_floor(diff[a] + rad, dd[a]);
         cnt[a]  = (hi < lo) ? 0 : hi - lo + 1;
         if (cnt[a] > ljpf_pkg::IMAGES_PER_AXIS) begin
            cnt[a] = ljpf_pkg::IMAGES_PER_AXIS;
            sat    = 1'b1;
         end
         kmin[a] = lo;
         total   = total * cnt[a];
      end
      for (longint n = 0; n < total; n++) begin
         rem    = n;
         s      = 64'd0;
         origin = 1'b1;
         for (int a = 0; a < ljpf_pkg::DIM; a++) begin
            k      = kmin[a] + rem % cnt[a];
            rem    = rem / cnt[a];
            if (k != 0) origin = 1'b0;
            zz[a]  = k * dd[a] - diff[a];
            mz     = 64'((zz[a] < 0) ? -zz[a] : zz[a]);
            s      = s + mz * mz;
         end
         if (excl && origin) continue;            // same molecule, own image
         if ((s == 64'd0) || (s >= r2cut)) continue;
         if (s <= 64'd1) begin
            sat = 1'b1;
            u   = '1;
         end else begin
            q = {1'b1, 64'd0} / {1'b0, s};
            u = q[63:0];
         end
         t1 = {16'd0, cfg_c12};
         t2 = {16'd0, cfg_c6};
         for (int j = 0; j < 7; j++)
            t1 = scaled_product(t1, u, 32, {16'd0, ljpf_pkg::MAX48}, sat);
         for (int j = 0; j < 4; j++)
            t2 = scaled_product(t2, u, 32, {16'd0, ljpf_pkg::MAX48}, sat);
         coef = longint'(t1) - longint'(t2) + cs;
         if (coef > F_HI) begin coef = F_HI; sat = 1'b1; end
         if (coef < F_LO) begin coef = F_LO; sat = 1'b1; end
         for (int a = 0; a < ljpf_pkg::DIM; a++) begin
            mz   = 64'((zz[a] < 0) ? -zz[a] : zz[a]);
            mc   = 64'((coef < 0) ? -coef : coef);
            pr   = scaled_product(mz, mc, 16, 64'd1 << 62, sat);
            term = ((zz[a] < 0) != (coef < 0)) ? -longint'(pr) : longint'(pr);
            f[a] = f[a] + term;
            if (f[a] > F_HI) begin f[a] = F_HI; sat = 1'b1; end
            if (f[a] < F_LO) begin f[a] = F_LO; sat = 1'b1; end
         end
      end
      r.f0  = f[0][47:0];
      r.f1  = f[1][47:0];
      r.f2  = f[2][47:0];
      r.sat = sat;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic pair_type random_pair();
      pair_type p;
      int       mode;
      mode = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
         if (mode < 7) begin
            // well inside the cutoff neighborhood: small coordinates, small offset
            p.xp[a] = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            p.yp[a] = p.xp[a] + int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
         end else if (mode < 8) begin
            p.xp[a] = $urandom;
            p.yp[a] = p.xp[a] + int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
         end else begin
            p.xp[a] = $urandom;
            p.yp[a] = $urandom;
         end
      end
      p.xm = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      p.ym = ($urandom_range(0, 2) == 0) ? p.xm : 16'($urandom);
      return p;
   endfunction

   // one request beat; the expectation is queued at the accepting edge
   task automatic send_pair(pair_type p, bit typed, force_type exp);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.x_pos_0    <= p.xp[0];
      req_if.x_pos_1    <= p.xp[1];
      req_if.x_pos_2    <= p.xp[2];
      req_if.y_pos_0    <= p.yp[0];
      req_if.y_pos_1    <= p.yp[1];
      req_if.y_pos_2    <= p.yp[2];
      req_if.x_molecule <= p.xm;
      req_if.y_molecule <= p.ym;
      req_if.valid      <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      force_q.push_back(typed ? exp : predict_force(p));
   endtask

   // let every owed beat come back before touching registers
   task automatic drain();
      req_if.valid <= 1'b0;
      while (force_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(ljpf_pkg::csr_index_type idx, logic [47:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         ljpf_pkg::CSR_BOX_X:   cfg_box[0]  = val[30:0];
         ljpf_pkg::CSR_BOX_Y:   cfg_box[1]  = val[30:0];
         ljpf_pkg::CSR_BOX_Z:   cfg_box[2]  = val[30:0];
         ljpf_pkg::CSR_CUTOFF:  cfg_cutoff  = val[30:0];
         ljpf_pkg::CSR_C12:     cfg_c12     = val;
         ljpf_pkg::CSR_C6:      cfg_c6      = val;
         ljpf_pkg::CSR_C_SHIFT: cfg_c_shift = val;
         default: ;
      endcase
   endtask

   task automatic apply_cfg(logic [30:0] bx, logic [30:0] by, logic [30:0] bz,
                            logic [30:0] cut, logic [47:0] c12, logic [47:0] c6,
                            logic [47:0] cs);
      write_csr(ljpf_pkg::CSR_BOX_X, {17'd0, bx});
      write_csr(ljpf_pkg::CSR_BOX_Y, {17'd0, by});
      write_csr(ljpf_pkg::CSR_BOX_Z, {17'd0, bz});
      write_csr(ljpf_pkg::CSR_CUTOFF, {17'd0, cut});
      write_csr(ljpf_pkg::CSR_C12, c12);
      write_csr(ljpf_pkg::CSR_C6, c6);
      write_csr(ljpf_pkg::CSR_C_SHIFT, cs);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase();
      force_type none;
      none = '0;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_pair(random_pair(), 1'b0, none);
      drain();
   endtask

   function automatic dir_row_type mk_row(int x0, int x1, int x2, int y0, int y1, int y2,
                                          int xm, int ym, bit typed, bit sat);
      dir_row_type r;
      r.p.xp[0] = x0; r.p.xp[1] = x1; r.p.xp[2] = x2;
      r.p.yp[0] = y0; r.p.yp[1] = y1; r.p.yp[2] = y2;
      r.p.xm    = 16'(xm);
      r.p.ym    = 16'(ym);
      r.typed   = typed;
      r.exp     = '0;
      r.exp.sat = sat;
      return r;
   endfunction

   // ---------------------------------------------------------------- main flow

   initial begin
      mismatches   = 0;
      hold_pending = 1'b0;
      cfg_box[0]   = ljpf_pkg::BOX_RESET;
      cfg_box[1]   = ljpf_pkg::BOX_RESET;
      cfg_box[2]   = ljpf_pkg::BOX_RESET;
      cfg_cutoff   = ljpf_pkg::CUTOFF_RESET;
      cfg_c12      = '0;
      cfg_c6       = '0;
      cfg_c_shift  = '0;

      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= ljpf_pkg::CSR_BOX_X;
      csr_wdata         <= '0;
      req_if.valid      <= 1'b0;
      req_if.x_pos_0    <= '0;
      req_if.x_pos_1    <= '0;
      req_if.x_pos_2    <= '0;
      req_if.y_pos_0    <= '0;
      req_if.y_pos_1    <= '0;
      req_if.y_pos_2    <= '0;
      req_if.x_molecule <= '0;
      req_if.y_molecule <= '0;

      // Directed table, reset registers (coefficients zero, so forces read off as zero).
      // Typed rows: same point; one-LSB offset (1/r^2 clamps); same offset with the
      // self image excluded; equal nonzero molecules on one point.
      dir_rows[0]  = mk_row(0, 0, 0, 0, 0, 0, 1, 2, 1'b1, 1'b0);
      dir_rows[1]  = mk_row(0, 0, 0, 1, 0, 0, 1, 2, 1'b1, 1'b1);
      dir_rows[2]  = mk_row(0, 0, 0, 1, 0, 0, 7, 7, 1'b1, 1'b0);
      dir_rows[3]  = mk_row(5, 5, 5, 5, 5, 5, 65535, 65535, 1'b1, 1'b0);
      dir_rows[4]  = mk_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 1'b0, 1'b0);
      dir_rows[5]  = mk_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 65535, 0, 1'b0, 1'b0);
      dir_rows[6]  = mk_row(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0,
                            3, 4, 1'b0, 1'b0);
      dir_rows[7]  = mk_row(32768, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);   // on the cutoff
      dir_rows[8]  = mk_row(32767, 0, 0, 0, 0, 0, 9, 9, 1'b0, 1'b0);
      dir_rows[9]  = mk_row(-1, -1, -1, 0, 0, 0, 0, 1, 1'b0, 1'b0);
      dir_rows[10] = mk_row(65535, 65535, 65535, 0, 0, 0, 12, 12, 1'b0, 1'b0);
      dir_rows[11] = mk_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                            32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 16'hAAAA, 16'h5555,
                            1'b0, 1'b0);
      dir_rows[12] = mk_row(0, 32'h8000_0000, 0, 0, 32'h8000_0000, 1, 0, 0, 1'b0, 1'b0);
      dir_rows[13] = mk_row(32768, 32768, 32768, 0, 0, 0, 1, 1, 1'b0, 1'b0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++)
         send_pair(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].exp);
      drain();

      // Phase 1: box 4.0, cutoff 2.5, unit coefficients, unshifted; receiver holds off once
      apply_cfg(31'd262144, 31'd262144, 31'd262144, 31'd163840,
                48'd1 << 24, 48'd1 << 24, 48'd0);
      hold_pending = 1'b1;
      random_phase();

      // Phase 2: uneven boxes, random coefficients and shift
      apply_cfg(31'd196608, 31'd327680, 31'd131072, 31'd98304,
                48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                48'({$urandom, $urandom}));
      random_phase();

      // Phase 3: zero box, 1 LSB box and largest box; zero cutoff gives zero force
      apply_cfg(31'd0, 31'd1, 31'h7FFF_FFFF, 31'd0,
                48'd1 << 24, 48'd1 << 24, 48'd1 << 20);
      random_phase();

      // Phase 4: largest boxes and cutoff, full repulsion, largest shift
      apply_cfg(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                ljpf_pkg::MAX48, 48'd0, ljpf_pkg::FMAX);
      random_phase();

      // Phase 5: unit box with huge cutoff clips image counts; full attraction, lowest shift
      apply_cfg(31'd65536, 31'd65536, 31'd65536, 31'h7FFF_FFFF,
                48'd0, ljpf_pkg::MAX48, ljpf_pkg::FMIN);
      random_phase();

      // Phase 6: box 2.0, cutoff 1.0, shifted potential
      apply_cfg(31'd131072, 31'd131072, 31'd131072, 31'd65536,
                48'd1 << 24, 48'd1 << 23, -48'sd1048576);
      random_phase();

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // ---------------------------------------------------------------- response side

   // receiver pacing: random gaps before each beat, one long hold-off to back the block up
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = $urandom_range(0, 4);
         if (hold_pending) begin
            hold_pending = 1'b0;
            gap          = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // compare every accepted response beat with the oldest owed force
   always @(posedge clock) begin
      force_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.f0  = rsp_if.force_0;
         got.f1  = rsp_if.force_1;
         got.f2  = rsp_if.force_2;
         got.sat = rsp_if.saturated;
         if (force_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response beat: %h %h %h sat=%b",
                        got.f0, got.f1, got.f2, got.sat);
         end else begin
            want = force_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("force mismatch: exp %h %h %h sat=%b, got %h %h %h sat=%b",
                           want.f0, want.f1, want.f2, want.sat,
                           got.f0, got.f1, got.f2, got.sat);
            end
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ljpf_pkg.sv
hw/rtl/ljpf_channels.sv
hw/rtl/ljpf_front.sv
hw/rtl/ljpf_queue.sv
hw/rtl/ljpf_back.sv
hw/rtl/lennard_jones_periodic_force_top.sv
dv/lennard_jones_periodic_force_top_tb.sv
